// ===== hw/rtl/mts_pkg.sv =====
// Shared constants, operation codes and control types of the min-tracking stack.
// No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ENTRY_WIDTH = VALUE_WIDTH + 2;
    localparam int PTR_WIDTH   = $clog2(STACK_DEPTH);
    localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_NONE = '1;

    typedef struct packed {
        logic take;
        logic fetch;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_fetch;
    } t_dp_status;

endpackage

// ===== hw/rtl/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/mts_datapath.sv =====
// Datapath of the min-tracking stack: count, minimum, cached top entry, entry RAM
// and result register. Depends on mts_pkg and mts_ram.
`timescale 1ns / 1ps

module mts_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mts_pkg::t_dp_cmd                       i_cmd,
    output mts_pkg::t_dp_status                    o_status,
    input  logic [1:0]                             i_operation,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] i_push_value,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] o_top_value,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] o_min_value,
    output logic                                   o_is_empty,
    output logic                                   o_rejected
);

    logic [mts_pkg::CNT_WIDTH-1:0]          r_count, n_count;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] r_min, n_min;
    logic signed [mts_pkg::ENTRY_WIDTH-1:0] r_top, n_top;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] r_out_top, r_out_min;
    logic                                   r_out_empty, r_out_rej;

    logic signed [mts_pkg::ENTRY_WIDTH-1:0] w_val_ext, w_min_ext, w_enc, w_restore, w_rd_data;
    logic signed [mts_pkg::ENTRY_WIDTH-1:0] w_nmin_ext;
    logic                                   w_full, w_empty, w_rej, w_wr_en, w_out_load;
    logic [mts_pkg::PTR_WIDTH-1:0]          w_wr_addr, w_rd_addr;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] w_res_top, w_res_min;

    assign w_val_ext = mts_pkg::ENTRY_WIDTH'(i_push_value);
    assign w_min_ext = mts_pkg::ENTRY_WIDTH'(r_min);
    assign w_enc     = (w_val_ext <<< 1) - w_min_ext;
    assign w_restore = (w_min_ext <<< 1) - r_top;
    assign w_full    = r_count == mts_pkg::CNT_WIDTH'(mts_pkg::STACK_DEPTH);
    assign w_empty   = r_count == '0;
    assign w_wr_addr = r_count[mts_pkg::PTR_WIDTH-1:0];
    assign w_rd_addr = mts_pkg::PTR_WIDTH'(r_count - mts_pkg::CNT_WIDTH'(2));

    assign o_status.pop_fetch = (i_operation == mts_pkg::OP_POP)
                                && (r_count > mts_pkg::CNT_WIDTH'(1));
    assign w_out_load = (i_cmd.take && !o_status.pop_fetch) || i_cmd.fetch;

    mts_ram #(
        .WIDTH(mts_pkg::ENTRY_WIDTH),
        .DEPTH(mts_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(n_top),
        .i_rd_en  (i_cmd.take && o_status.pop_fetch),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_top   = r_top;
        w_rej   = 1'b0;
        w_wr_en = 1'b0;
        if (i_cmd.fetch) begin
            n_top = w_rd_data;
        end else if (i_cmd.take) begin
            unique case (i_operation)
                mts_pkg::OP_PUSH: begin
                    if (w_full) begin
                        w_rej = 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = r_count + mts_pkg::CNT_WIDTH'(1);
                        if (w_empty) begin
                            n_top = w_val_ext;
                            n_min = i_push_value;
                        end else if (w_val_ext > w_min_ext) begin
                            n_top = w_val_ext;
                        end else begin
                            n_top = w_enc;
                            n_min = i_push_value;
                        end
                    end
                end
                mts_pkg::OP_POP: begin
                    if (w_empty) begin
                        w_rej = 1'b1;
                    end else begin
                        n_count = r_count - mts_pkg::CNT_WIDTH'(1);
                        if (r_top < w_min_ext) begin
                            n_min = w_restore[mts_pkg::VALUE_WIDTH-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_nmin_ext = mts_pkg::ENTRY_WIDTH'(n_min);

    always_comb begin
        if (n_count == '0) begin
            w_res_top = mts_pkg::VAL_NONE;
            w_res_min = mts_pkg::VAL_NONE;
        end else begin
            w_res_min = n_min;
            w_res_top = (n_top < w_nmin_ext) ? n_min : n_top[mts_pkg::VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= mts_pkg::VAL_MAX;
        end else begin
            r_count <= n_count;
            r_min   <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (w_out_load) begin
            r_out_top   <= w_res_top;
            r_out_min   <= w_res_min;
            r_out_empty <= n_count == '0;
            r_out_rej   <= w_rej;
        end
    end

    assign o_top_value = r_out_top;
    assign o_min_value = r_out_min;
    assign o_is_empty  = r_out_empty;
    assign o_rejected  = r_out_rej;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mts_pkg::CNT_WIDTH'(mts_pkg::STACK_DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + mts_pkg::CNT_WIDTH'(1)
         || r_count + mts_pkg::CNT_WIDTH'(1) == $past(r_count)))
        else $error("entry count moved by more than one");

    a_full_push_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && i_operation == mts_pkg::OP_PUSH && w_full) |=>
        (r_out_rej && r_count == $past(r_count)))
        else $error("push on full stack not rejected");

endmodule

// ===== hw/rtl/mts_ctrl.sv =====
// Controller of the min-tracking stack: handshakes and the top-refill sequence after a pop.
// Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  mts_pkg::t_dp_status i_status,
    output mts_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign o_cmd.take  = i_valid && !o_stall;
    assign o_cmd.fetch = r_state == S_FETCH;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take) begin
                    if (i_status.pop_fetch) begin
                        n_state = S_FETCH;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_fetch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_IDLE && r_out_valid))
        else $error("refill did not complete in one cycle");

    a_fetch_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> o_stall)
        else $error("input taken during refill");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// Push, peek, rejected and emptying pop operations give their result in the cycle after acceptance;
// a pop that leaves entries behind reads the new top from the entry RAM, then loads the result
// register in a refill state that stalls the input. Push and peek take 1 per cycle unless the receiver stalls.
// Reset (synchronous, active low) empties the stack and sets the minimum to the largest value;
// entry RAM contents are not cleared.
`timescale 1ns / 1ps

module min_tracking_stack (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_operation,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] i_push_value,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] o_top_value,
    output logic signed [mts_pkg::VALUE_WIDTH-1:0] o_min_value,
    output logic                                   o_is_empty,
    output logic                                   o_rejected
);

    mts_pkg::t_dp_cmd    w_cmd;
    mts_pkg::t_dp_status w_status;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_status(w_status),
        .o_cmd   (w_cmd)
    );

    mts_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_operation (i_operation),
        .i_push_value(i_push_value),
        .o_top_value (o_top_value),
        .o_min_value (o_min_value),
        .o_is_empty  (o_is_empty),
        .o_rejected  (o_rejected)
    );

endmodule

// ===== dv/min_stack_checker.sv =====
// Checker for the min-tracking stack: watches both channels, keeps a shadow stack
// and compares every result field by field. Depends on mts_pkg.
`timescale 1ns / 1ps

module min_stack_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_stall_in,
    input  logic [1:0]                             i_operation,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] i_push_value,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] i_top_value,
    input  logic signed [mts_pkg::VALUE_WIDTH-1:0] i_min_value,
    input  logic                                   i_is_empty,
    input  logic                                   i_rejected,
    output int                                     o_errors,
    output int                                     o_pending
);

    typedef struct packed {
        logic signed [mts_pkg::VALUE_WIDTH-1:0] top;
        logic signed [mts_pkg::VALUE_WIDTH-1:0] min;
        logic                                   empty;
        logic                                   rejected;
    } t_stack_view;

    longint      shadow_entries [mts_pkg::STACK_DEPTH];
    int          shadow_count;
    longint      shadow_min;
    t_stack_view predicted_views [$];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        shadow_count = 0;
        shadow_min   = longint'(mts_pkg::VAL_MAX);
    end

    function automatic t_stack_view step_shadow_stack(
        input logic [1:0] op,
        input logic signed [mts_pkg::VALUE_WIDTH-1:0] val
    );
        t_stack_view view;
        longint      held;
        logic        refused;
        refused = 1'b0;
        case (op)
            mts_pkg::OP_PUSH: begin
                if (shadow_count >= mts_pkg::STACK_DEPTH) begin
                    refused = 1'b1;
                end else if (shadow_count == 0) begin
                    shadow_entries[0] = longint'(val);
                    shadow_min        = longint'(val);
                    shadow_count      = 1;
                end else if (longint'(val) > shadow_min) begin
                    shadow_entries[shadow_count] = longint'(val);
                    shadow_count++;
                end else begin
                    // encode the old minimum into the entry
                    shadow_entries[shadow_count] = 2 * longint'(val) - shadow_min;
                    shadow_min                   = longint'(val);
                    shadow_count++;
                end
            end
            mts_pkg::OP_POP: begin
                if (shadow_count == 0) begin
                    refused = 1'b1;
                end else begin
                    shadow_count--;
                    held = shadow_entries[shadow_count];
                    if (held < shadow_min) shadow_min = 2 * shadow_min - held;
                end
            end
            default: ;
        endcase
        view.rejected = refused;
        if (shadow_count == 0) begin
            view.top   = mts_pkg::VAL_NONE;
            view.min   = mts_pkg::VAL_NONE;
            view.empty = 1'b1;
        end else begin
            held       = shadow_entries[shadow_count - 1];
            view.top   = (held < shadow_min) ? shadow_min[mts_pkg::VALUE_WIDTH-1:0]
                                             : held[mts_pkg::VALUE_WIDTH-1:0];
            view.min   = shadow_min[mts_pkg::VALUE_WIDTH-1:0];
            view.empty = 1'b0;
        end
        return view;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_stack_view want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_min   = longint'(mts_pkg::VAL_MAX);
            predicted_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_views.size() == 0) begin
                    report_mismatch("unexpected result, outstanding count", 1, 0);
                end else begin
                    want = predicted_views.pop_front();
                    if (i_top_value !== want.top)
                        report_mismatch("top_value", i_top_value, want.top);
                    if (i_min_value !== want.min)
                        report_mismatch("min_value", i_min_value, want.min);
                    if (i_is_empty !== want.empty)
                        report_mismatch("is_empty", i_is_empty, want.empty);
                    if (i_rejected !== want.rejected)
                        report_mismatch("rejected", i_rejected, want.rejected);
                end
            end
            if (i_valid && !i_stall_in)
                predicted_views.push_back(step_shadow_stack(i_operation, i_push_value));
        end
        o_pending = predicted_views.size();
    end

endmodule

// ===== dv/tb_min_tracking_stack.sv =====
// Top of the min-tracking stack testbench: clock, reset, directed and random stimulus,
// receiver back-pressure and the verdict. Depends on mts_pkg, the block and min_stack_checker.
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [mts_pkg::VALUE_WIDTH-1:0] VAL_MIN =
        {1'b1, {(mts_pkg::VALUE_WIDTH-1){1'b0}}};
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 150;
    localparam int ITEM_GOAL  = 900;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_stall;
    logic [1:0]                             i_operation;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] i_push_value;
    logic                                   o_valid;
    logic                                   i_stall;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] o_top_value;
    logic signed [mts_pkg::VALUE_WIDTH-1:0] o_min_value;
    logic                                   o_is_empty;
    logic                                   o_rejected;

    int   error_count;
    int   outstanding;
    int   sent_items;
    int   idle_cycles;
    bit   tx_gaps;
    bit   rx_gaps;
    bit   rx_hold_req;

    min_tracking_stack DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_top_value  (o_top_value),
        .o_min_value  (o_min_value),
        .o_is_empty   (o_is_empty),
        .o_rejected   (o_rejected)
    );

    min_stack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_top_value  (o_top_value),
        .i_min_value  (o_min_value),
        .i_is_empty   (o_is_empty),
        .i_rejected   (o_rejected),
        .o_errors     (error_count),
        .o_pending    (outstanding)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [mts_pkg::VALUE_WIDTH-1:0] pick_value();
        logic signed [mts_pkg::VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
            4: begin
                case ($urandom_range(0, 6))
                    0: v = mts_pkg::VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = mts_pkg::VAL_MAX - 1;
                    3: v = VAL_MIN + 1;
                    4: v = 0;
                    5: v = 1;
                    default: v = mts_pkg::VAL_NONE;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct) return mts_pkg::OP_PUSH;
        case ($urandom_range(0, 9))
            0:       return OP_UNUSED;
            1, 2:    return mts_pkg::OP_PEEK;
            default: return mts_pkg::OP_POP;
        endcase
    endfunction

    task automatic send_op(input logic [1:0] op,
                           input logic signed [mts_pkg::VALUE_WIDTH-1:0] val);
        int gap;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_push_value <= val;
        do @(posedge i_clk); while (o_stall);
        sent_items++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_LEN;
            end else if (rx_gaps && hold_left == 0 && burst_left == 0
                         && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 15);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (burst_left > 0) begin
                i_stall <= 1'b1;
                burst_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int seg_len;
        int push_pct;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_operation  = mts_pkg::OP_PEEK;
        i_push_value = '0;
        sent_items   = 0;
        tx_gaps      = 1'b0;
        rx_gaps      = 1'b0;
        rx_hold_req  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty stack, reserved code, min encoding on equal and smaller values
        send_op(mts_pkg::OP_PEEK, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(OP_UNUSED, mts_pkg::VAL_NONE);
        send_op(mts_pkg::OP_PUSH, 5);
        send_op(mts_pkg::OP_PUSH, 7);
        send_op(mts_pkg::OP_PUSH, 5);
        send_op(mts_pkg::OP_PUSH, 3);
        send_op(mts_pkg::OP_PEEK, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_PUSH, mts_pkg::VAL_MAX);
        send_op(mts_pkg::OP_PUSH, VAL_MIN);
        send_op(mts_pkg::OP_PUSH, VAL_MIN);
        send_op(mts_pkg::OP_PUSH, mts_pkg::VAL_MAX);
        send_op(mts_pkg::OP_PUSH, mts_pkg::VAL_NONE);
        send_op(OP_UNUSED, VAL_MIN);
        send_op(mts_pkg::OP_POP, mts_pkg::VAL_MAX);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);
        send_op(mts_pkg::OP_POP, 0);

        // back-pressure: fill past full while the receiver holds off
        wait_drained();
        rx_hold_req = 1'b1;
        repeat (80) send_op(mts_pkg::OP_PUSH, pick_value());
        wait_drained();
        repeat (70) send_op(mts_pkg::OP_POP, pick_value());

        while (sent_items < ITEM_GOAL - 100) begin
            seg_len = $urandom_range(40, 120);
            case ($urandom_range(0, 3))
                0:       push_pct = 25;
                1:       push_pct = 50;
                2:       push_pct = 70;
                default: push_pct = 92;
            endcase
            tx_gaps = ($urandom_range(0, 2) != 0);
            rx_gaps = ($urandom_range(0, 2) != 0);
            repeat (seg_len) send_op(pick_op(push_pct), pick_value());
        end

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (100) send_op(pick_op(55), pick_value());

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
